>>> hw/rtl/tpsc_pkg.sv
`timescale 1ns / 1ps

package tpsc_pkg;

  localparam int RAW_W     = 16;
  localparam int MAG_W     = 16;
  localparam int DV_W      = 15;
  localparam int V0_W      = 15;
  localparam int NUM_W     = 31;
  localparam int DEN_W     = 16;
  localparam int VAL_W     = 33;
  localparam int OUT_W     = 24;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_W     = 16;
  localparam int HUM_PT_W  = 8;
  localparam int TEMP_PT_W = 10;
  localparam int HUM_SHIFT = 7;
  localparam int TEMP_SHIFT = 5;

  localparam logic signed [VAL_W-1:0] HUM_MAX = VAL_W'(25600);
  localparam logic signed [VAL_W-1:0] OUT_MAX = VAL_W'(8388607);
  localparam logic signed [VAL_W-1:0] OUT_MIN = -VAL_W'(8388608);

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_CLAMP = 2'd1,
    ST_SPAN  = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HUM_POINT0_X2  = 8'd0,
    REG_HUM_POINT1_X2  = 8'd1,
    REG_TEMP_POINT0_X8 = 8'd2,
    REG_TEMP_POINT1_X8 = 8'd3,
    REG_HUM_RAW_POINT0 = 8'd4,
    REG_HUM_RAW_POINT1 = 8'd5,
    REG_TEMP_RAW_POINT0 = 8'd6,
    REG_TEMP_RAW_POINT1 = 8'd7
  } reg_idx_t;

  typedef struct packed {
    logic [HUM_PT_W-1:0]  hum_point0_x2;
    logic [HUM_PT_W-1:0]  hum_point1_x2;
    logic [TEMP_PT_W-1:0] temp_point0_x8;
    logic [TEMP_PT_W-1:0] temp_point1_x8;
    logic [RAW_W-1:0]     hum_raw_point0;
    logic [RAW_W-1:0]     hum_raw_point1;
    logic [RAW_W-1:0]     temp_raw_point0;
    logic [RAW_W-1:0]     temp_raw_point1;
  } cal_t;

  typedef struct packed {
    logic             op;
    logic             zero;
    logic             neg;
    logic [MAG_W-1:0] d_mag;
    logic [DV_W-1:0]  dv_mag;
    logic [DEN_W-1:0] den;
    logic [V0_W-1:0]  v0;
  } prep_t;

  typedef struct packed {
    logic             op;
    logic             zero;
    logic             neg;
    logic [DEN_W-1:0] den;
    logic [V0_W-1:0]  v0;
  } div_side_t;

  typedef struct packed {
    div_side_t        side;
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] work;
  } div_t;

endpackage

>>> hw/rtl/tpsc_front.sv
`timescale 1ns / 1ps

module tpsc_front import tpsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             op,
  input  logic [RAW_W-1:0] raw_sample,
  input  cal_t             cal,
  output logic             out_valid,
  input  logic             out_ready,
  output div_t             dout
);

  logic [RAW_W-1:0]  out0;
  logic [RAW_W-1:0]  out1;
  logic [V0_W-1:0]   v0;
  logic [V0_W-1:0]   v1;
  logic [RAW_W:0]    d;
  logic [RAW_W:0]    d_abs;
  logic [RAW_W:0]    den;
  logic [RAW_W:0]    den_abs;
  logic [V0_W:0]     dv;
  logic [V0_W:0]     dv_abs;
  prep_t             p_next;
  prep_t             p;
  logic              p_valid;
  logic              s1_ready;
  logic              s2_ready;
  logic [NUM_W-1:0]  prod;
  div_t              o;
  logic              o_valid;

  always_comb begin
    if (op) begin
      out0 = cal.temp_raw_point0;
      out1 = cal.temp_raw_point1;
      v0   = {cal.temp_point0_x8, TEMP_SHIFT'(0)};
      v1   = {cal.temp_point1_x8, TEMP_SHIFT'(0)};
    end else begin
      out0 = cal.hum_raw_point0;
      out1 = cal.hum_raw_point1;
      v0   = {cal.hum_point0_x2, HUM_SHIFT'(0)};
      v1   = {cal.hum_point1_x2, HUM_SHIFT'(0)};
    end
    d       = {raw_sample[RAW_W-1], raw_sample} - {out0[RAW_W-1], out0};
    den     = {out1[RAW_W-1], out1} - {out0[RAW_W-1], out0};
    dv      = {1'b0, v1} - {1'b0, v0};
    d_abs   = d[RAW_W] ? (~d + 1'b1) : d;
    den_abs = den[RAW_W] ? (~den + 1'b1) : den;
    dv_abs  = dv[V0_W] ? (~dv + 1'b1) : dv;
    p_next.op     = op;
    p_next.zero   = (out0 == out1);
    p_next.neg    = d[RAW_W] ^ dv[V0_W] ^ den[RAW_W];
    p_next.d_mag  = d_abs[MAG_W-1:0];
    p_next.dv_mag = dv_abs[DV_W-1:0];
    p_next.den    = den_abs[DEN_W-1:0];
    p_next.v0     = v0;
  end

  assign s2_ready = !o_valid || out_ready;
  assign s1_ready = !p_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        p_valid <= in_valid;
      end
      if (s2_ready) begin
        o_valid <= p_valid;
      end
    end
  end

  assign prod = NUM_W'(p.d_mag) * NUM_W'(p.dv_mag);

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      p <= p_next;
    end
    if (s2_ready && p_valid) begin
      o.side.op   <= p.op;
      o.side.zero <= p.zero;
      o.side.neg  <= p.neg;
      o.side.den  <= p.den;
      o.side.v0   <= p.v0;
      o.rem       <= '0;
      o.work      <= prod;
    end
  end

  assign out_valid = o_valid;
  assign dout      = o;

endmodule

>>> hw/rtl/tpsc_div_cell.sv
`timescale 1ns / 1ps

module tpsc_div_cell import tpsc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  div_t din,
  output logic out_valid,
  input  logic out_ready,
  output div_t dout
);

  logic [DEN_W:0]   t;
  logic [DEN_W+1:0] diff;
  logic             ge;
  div_t             nxt;
  div_t             q;
  logic             valid;

  always_comb begin
    t         = {din.rem, din.work[NUM_W-1]};
    diff      = {1'b0, t} - {2'b0, din.side.den};
    ge        = !diff[DEN_W+1];
    nxt.side  = din.side;
    nxt.rem   = ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
    nxt.work  = {din.work[NUM_W-2:0], ge};
  end

  assign in_ready = !valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q <= nxt;
    end
  end

  assign out_valid = valid;
  assign dout      = q;

endmodule

>>> hw/rtl/tpsc_back.sv
`timescale 1ns / 1ps

module tpsc_back import tpsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  div_t              din,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [OUT_W-1:0]  value_q8,
  output logic [STAT_W-1:0] status
);

  logic signed [VAL_W-1:0] v0_ext;
  logic signed [VAL_W-1:0] q_ext;
  logic signed [VAL_W-1:0] val;
  logic [OUT_W-1:0]        value_next;
  status_t                 status_next;
  logic                    valid;
  logic                    op_q;
  logic [OUT_W-1:0]        value_r;
  status_t                 status_r;

  always_comb begin
    v0_ext = $signed({(VAL_W-V0_W)'(0), din.side.v0});
    q_ext  = $signed({(VAL_W-NUM_W)'(0), din.work});
    val    = din.side.neg ? (v0_ext - q_ext) : (v0_ext + q_ext);
    value_next  = val[OUT_W-1:0];
    status_next = ST_OK;
    if (din.side.zero) begin
      value_next  = '0;
      status_next = ST_SPAN;
    end else if (din.side.op) begin
      if (val > OUT_MAX) begin
        value_next  = OUT_MAX[OUT_W-1:0];
        status_next = ST_CLAMP;
      end else if (val < OUT_MIN) begin
        value_next  = OUT_MIN[OUT_W-1:0];
        status_next = ST_CLAMP;
      end
    end else begin
      if (val > HUM_MAX) begin
        value_next  = HUM_MAX[OUT_W-1:0];
        status_next = ST_CLAMP;
      end else if (val < 0) begin
        value_next  = '0;
        status_next = ST_CLAMP;
      end
    end
  end

  assign in_ready = !valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      value_r  <= value_next;
      status_r <= status_next;
      op_q     <= din.side.op;
    end
  end

  assign out_valid = valid;
  assign value_q8  = value_r;
  assign status    = status_r;

  a_span_zero: assert property (@(posedge clk) disable iff (rst)
    valid && status_r == ST_SPAN |-> value_r == '0)
    else $error("zero span result not zero");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    valid |-> (status_r == ST_OK || status_r == ST_CLAMP || status_r == ST_SPAN))
    else $error("undefined status code");

  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    valid && !op_q |-> !value_r[OUT_W-1] && (value_r <= HUM_MAX[OUT_W-1:0]))
    else $error("humidity outside 0 to 100 percent RH");

  a_clamp_hum_edge: assert property (@(posedge clk) disable iff (rst)
    valid && !op_q && status_r == ST_CLAMP |->
      (value_r == '0 || value_r == HUM_MAX[OUT_W-1:0]))
    else $error("clamped humidity not at a limit");

endmodule

>>> hw/rtl/two_point_sensor_calibration.sv
`timescale 1ns / 1ps

// channel  | direction | handshake            | payload
// in       | input     | in_valid / in_stall  | op, raw_sample
// out      | output    | out_valid / out_stall| value_q8, status
// cfg      | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One sample per cycle while out_stall is low; stages: select and subtract,
// multiply, 31 restoring divider cells (one quotient bit each), clamp and output.
// Every stage has its own valid bit, so bubbles collapse and the input keeps
// flowing while a result waits at the output, until the bubbles are filled.
// Reset clears all valid bits and calibration registers to 0.
// cfg_ready is always high; writes take effect for the next accepted sample.

module two_point_sensor_calibration import tpsc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 op,
  input  logic [RAW_W-1:0]     raw_sample,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OUT_W-1:0]     value_q8,
  output logic [STAT_W-1:0]    status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  cal_t cal;
  logic front_ready;
  div_t chain [0:NUM_W];
  logic chain_valid [0:NUM_W];
  logic chain_ready [0:NUM_W];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HUM_POINT0_X2:   cal.hum_point0_x2   <= cfg_data[HUM_PT_W-1:0];
        REG_HUM_POINT1_X2:   cal.hum_point1_x2   <= cfg_data[HUM_PT_W-1:0];
        REG_TEMP_POINT0_X8:  cal.temp_point0_x8  <= cfg_data[TEMP_PT_W-1:0];
        REG_TEMP_POINT1_X8:  cal.temp_point1_x8  <= cfg_data[TEMP_PT_W-1:0];
        REG_HUM_RAW_POINT0:  cal.hum_raw_point0  <= cfg_data[RAW_W-1:0];
        REG_HUM_RAW_POINT1:  cal.hum_raw_point1  <= cfg_data[RAW_W-1:0];
        REG_TEMP_RAW_POINT0: cal.temp_raw_point0 <= cfg_data[RAW_W-1:0];
        REG_TEMP_RAW_POINT1: cal.temp_raw_point1 <= cfg_data[RAW_W-1:0];
        default: ;
      endcase
    end
  end

  tpsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (front_ready),
    .op         (op),
    .raw_sample (raw_sample),
    .cal        (cal),
    .out_valid  (chain_valid[0]),
    .out_ready  (chain_ready[0]),
    .dout       (chain[0])
  );

  assign in_stall = !front_ready;

  for (genvar k = 0; k < NUM_W; k++) begin : g_cell
    tpsc_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[k]),
      .in_ready  (chain_ready[k]),
      .din       (chain[k]),
      .out_valid (chain_valid[k+1]),
      .out_ready (chain_ready[k+1]),
      .dout      (chain[k+1])
    );
  end

  tpsc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (chain_valid[NUM_W]),
    .in_ready  (chain_ready[NUM_W]),
    .din       (chain[NUM_W]),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value_q8  (value_q8),
    .status    (status)
  );

endmodule
